@@ rtl/wsel_pkg.sv @@
// ============================================================================
// wsel_pkg
// Types and codes shared by the weight-sorted entry list and its cells.
// ============================================================================
package wsel_pkg;

    localparam int TYPE_W    = 2;
    localparam int KIND_W    = 1;
    localparam int PAYLOAD_W = 9;
    localparam int WEIGHT_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int ECOUNT_W  = 9;

    localparam logic [TYPE_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [WEIGHT_W-1:0]  weight;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   app;
        logic   pop;
        entry_t elem;
    } cell_ctrl_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 out_valid;
        logic [KIND_W-1:0]    out_kind;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [WEIGHT_W-1:0]  out_weight;
        logic [ECOUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

@@ rtl/wsel_req_if.sv @@
// ============================================================================
// wsel_req_if
// Request channel: one item per valid/ready handshake.
// ============================================================================
interface wsel_req_if;
    logic                            valid;
    logic                            ready;
    logic [wsel_pkg::TYPE_W-1:0]     req_type;
    logic [wsel_pkg::KIND_W-1:0]     elem_kind;
    logic [wsel_pkg::PAYLOAD_W-1:0]  elem_payload;
    logic [wsel_pkg::WEIGHT_W-1:0]   elem_weight;

    modport source (
        output valid,
        output req_type,
        output elem_kind,
        output elem_payload,
        output elem_weight,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  elem_kind,
        input  elem_payload,
        input  elem_weight,
        output ready
    );
endinterface

@@ rtl/wsel_rsp_if.sv @@
// ============================================================================
// wsel_rsp_if
// Response channel: one item per valid/ready handshake.
// ============================================================================
interface wsel_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [wsel_pkg::STATUS_W-1:0]   status;
    logic                            out_valid;
    logic [wsel_pkg::KIND_W-1:0]     out_kind;
    logic [wsel_pkg::PAYLOAD_W-1:0]  out_payload;
    logic [wsel_pkg::WEIGHT_W-1:0]   out_weight;
    logic [wsel_pkg::ECOUNT_W-1:0]   entry_count;

    modport source (
        output valid,
        output status,
        output out_valid,
        output out_kind,
        output out_payload,
        output out_weight,
        output entry_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  out_valid,
        input  out_kind,
        input  out_payload,
        input  out_weight,
        input  entry_count,
        output ready
    );
endinterface

@@ rtl/wsel_cell.sv @@
// ============================================================================
// wsel_cell
// One slot of the list. Slot 0 holds the tail; higher slots go toward the head.
// Shift toward the head on an insert above the insert point, shift toward the
// tail on a remove, and pass the "all heavier up to here" flag down the row.
// ============================================================================
module wsel_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                   clk,
    input  wsel_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]       count,
    input  logic                   s_above,
    input  logic                   s_below,
    input  wsel_pkg::entry_t       prev_data,
    input  wsel_pkg::entry_t       next_data,
    output logic                   s_out,
    output wsel_pkg::entry_t       data
);

    wsel_pkg::entry_t data_reg;
    wsel_pkg::entry_t data_next;
    logic             occ;
    logic             heavier;

    assign occ     = CNT_W'(IDX) < count;
    assign heavier = data_reg.weight > ctrl.elem.weight;
    assign s_out   = s_above & (!occ | heavier | ctrl.app);
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (s_below)
            begin
                data_next = prev_data;
            end
            else if (s_out)
            begin
                data_next = ctrl.elem;
            end
        end
        else if (ctrl.pop)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/weight_sorted_entry_list.sv @@
// ============================================================================
// weight_sorted_entry_list
// Bounded list of (kind, payload, weight) entries; inserts keep it heaviest
// first, appends join the tail; shifting compare cells, tail in cell 0.
//
//   channel  modport  carries
//   req      sink     req_type, elem_kind, elem_payload, elem_weight
//   rsp      source   status, out_valid, out_kind, out_payload, out_weight,
//                     entry_count
//
// Each item is applied to the cell row in the cycle it is accepted; its
// response item is registered and shown the next cycle.
// A new item is taken while the response register is empty or being taken,
// so the list sustains one item per cycle while responses are taken.
// Reset clears the entry count and the response register; slot contents
// are left as they are and are never read before being written.
// ============================================================================
module weight_sorted_entry_list #(
    parameter int DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    wsel_req_if.sink     req,
    wsel_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 accept;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    wsel_pkg::rsp_t       rsp_reg;
    wsel_pkg::rsp_t       rsp_next;
    logic                 full;
    logic                 empty;
    logic                 is_add;
    logic                 is_remove;
    wsel_pkg::cell_ctrl_t ctrl;
    logic [DEPTH:0]       s_vec;
    wsel_pkg::entry_t     cell_q [DEPTH];
    logic [CNT_W+wsel_pkg::ECOUNT_W-1:0] count_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign is_add    = (req.req_type == wsel_pkg::REQ_APPEND)
                    || (req.req_type == wsel_pkg::REQ_INSERT);
    assign is_remove = req.req_type == wsel_pkg::REQ_REMOVE;

    assign ctrl.ins          = accept && is_add && !full;
    assign ctrl.app          = req.req_type == wsel_pkg::REQ_APPEND;
    assign ctrl.pop          = accept && is_remove && !empty;
    assign ctrl.elem.kind    = req.elem_kind;
    assign ctrl.elem.payload = req.elem_payload;
    assign ctrl.elem.weight  = req.elem_weight;

    assign s_vec[DEPTH] = 1'b1;

    genvar j;
    generate
        for (j = 0; j < DEPTH; j++)
        begin : g_cell
            wsel_pkg::entry_t prev_d;
            wsel_pkg::entry_t next_d;
            logic             s_bel;

            if (j == 0)
            begin : g_tail
                assign prev_d = ctrl.elem;
                assign s_bel  = 1'b0;
            end
            else
            begin : g_mid
                assign prev_d = cell_q[j-1];
                assign s_bel  = s_vec[j-1];
            end

            if (j == DEPTH - 1)
            begin : g_head
                assign next_d = cell_q[j];
            end
            else
            begin : g_body
                assign next_d = cell_q[j+1];
            end

            wsel_cell #(
                .IDX   (j),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .s_above   (s_vec[j+1]),
                .s_below   (s_bel),
                .prev_data (prev_d),
                .next_data (next_d),
                .s_out     (s_vec[j]),
                .data      (cell_q[j])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = {{wsel_pkg::ECOUNT_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.status      = wsel_pkg::ST_DONE;
        rsp_next.entry_count = count_ext[wsel_pkg::ECOUNT_W-1:0];
        if (is_add && full)
        begin
            rsp_next.status = wsel_pkg::ST_FULL;
        end
        else if (is_remove && empty)
        begin
            rsp_next.status = wsel_pkg::ST_EMPTY;
        end
        else if (is_remove)
        begin
            rsp_next.out_valid   = 1'b1;
            rsp_next.out_kind    = cell_q[0].kind;
            rsp_next.out_payload = cell_q[0].payload;
            rsp_next.out_weight  = cell_q[0].weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= rsp_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_reg.status;
    assign rsp.out_valid   = rsp_reg.out_valid;
    assign rsp.out_kind    = rsp_reg.out_kind;
    assign rsp.out_payload = rsp_reg.out_payload;
    assign rsp.out_weight  = rsp_reg.out_weight;
    assign rsp.entry_count = rsp_reg.entry_count;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_split_monotone : assert property (@(posedge clk) disable iff (!rst_n)
        (s_vec[DEPTH-1:0] & ~s_vec[DEPTH:1]) == '0)
        else $error("insert split flag not monotone along the row");

    a_add_count : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count did not advance on insert");

    a_pop_data : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> rsp_reg.out_valid && rsp_reg.out_weight == $past(cell_q[0].weight))
        else $error("removed item does not match tail slot");

    a_empty_status : assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_remove && empty |=> rsp_reg.status == wsel_pkg::ST_EMPTY
            && !rsp_reg.out_valid)
        else $error("remove on empty list not flagged");

endmodule

@@ tb/entry_list_monitor.sv @@
// ============================================================================
// entry_list_monitor
// Watches the request and response channels of the weight-sorted entry list.
// Keeps its own copy of the list, works out the response that each accepted
// request must produce, and compares every accepted response field by field
// with the oldest outstanding answer.
// ============================================================================
module entry_list_monitor #(
    parameter int DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    wsel_req_if  req,
    wsel_rsp_if  rsp,
    output int   mismatch_count,
    output int   answers_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsel_pkg::*;

    entry_t      slots [DEPTH];
    int unsigned held;
    rsp_t        answers [$];
    rsp_t        want;
    entry_t      arrived;

    function automatic rsp_t apply_to_list(logic [TYPE_W-1:0] op, entry_t incoming);
        rsp_t        r;
        int unsigned pos;
        r        = '0;
        r.status = ST_DONE;
        case (op)
            REQ_APPEND:
            begin
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slots[held] = incoming;
                    held++;
                end
            end
            REQ_REMOVE:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    held--;
                    r.out_valid   = 1'b1;
                    r.out_kind    = slots[held].kind;
                    r.out_payload = slots[held].payload;
                    r.out_weight  = slots[held].weight;
                end
            end
            REQ_INSERT:
            begin
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held && slots[pos].weight > incoming.weight)
                        pos++;
                    for (int unsigned k = held; k > pos; k--)
                        slots[k] = slots[k - 1];
                    slots[pos] = incoming;
                    held++;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = ECOUNT_W'(held);
        return r;
    endfunction

    task automatic compare_field(string name, logic [WEIGHT_W-1:0] exp_val,
                                 logic [WEIGHT_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            held = 0;
            answers.delete();
            answers_due <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers.size() == 0)
                begin
                    $error("response item with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = answers.pop_front();
                    compare_field("status", WEIGHT_W'(want.status),
                                  WEIGHT_W'(rsp.status));
                    compare_field("out_valid", WEIGHT_W'(want.out_valid),
                                  WEIGHT_W'(rsp.out_valid));
                    compare_field("out_kind", WEIGHT_W'(want.out_kind),
                                  WEIGHT_W'(rsp.out_kind));
                    compare_field("out_payload", WEIGHT_W'(want.out_payload),
                                  WEIGHT_W'(rsp.out_payload));
                    compare_field("out_weight", want.out_weight, rsp.out_weight);
                    compare_field("entry_count", WEIGHT_W'(want.entry_count),
                                  WEIGHT_W'(rsp.entry_count));
                end
            end
            if (req.valid && req.ready)
            begin
                arrived = {req.elem_kind, req.elem_payload, req.elem_weight};
                answers.push_back(apply_to_list(req.req_type, arrived));
            end
            answers_due <= answers.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench
// Drives requests into the weight-sorted entry list with random bursts and
// gaps while the response side stalls on its own pattern. A short directed
// run covers empty, equal-weight, tail and head placement, unordered appends
// and the unused request code; random phases then fill the list to full and
// drain it to empty. The monitor beside the block checks every response.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsel_pkg::*;

    localparam int                LIST_DEPTH = 256;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int                RANDOM_REQUESTS = 1000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   answers_due;
    int   burst_left;
    int   ready_mode;
    int   ready_left;
    int   sent;
    int   phase_len;
    int   add_pct;
    bit   first_phase;

    wsel_req_if req_ch ();
    wsel_rsp_if rsp_ch ();

    weight_sorted_entry_list #(
        .DEPTH (LIST_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    entry_list_monitor #(
        .DEPTH (LIST_DEPTH)
    ) monitor_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatches),
        .answers_due    (answers_due)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        ready_left   = 0;
        forever
        begin
            @(posedge clk);
            if (ready_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                ready_left = $urandom_range(16, 96);
            end
            ready_left--;
            case (ready_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((ready_left % 8) < 5);
            endcase
        end
    end

    task automatic offer_request(input logic [TYPE_W-1:0]    op,
                                 input logic [KIND_W-1:0]    kind,
                                 input logic [PAYLOAD_W-1:0] payload,
                                 input logic [WEIGHT_W-1:0]  weight);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= op;
        req_ch.elem_kind    <= kind;
        req_ch.elem_payload <= payload;
        req_ch.elem_weight  <= weight;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return WEIGHT_W'($urandom_range(0, 15));
            1:       return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return WEIGHT_W'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [TYPE_W-1:0] pick_request(int grow_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return REQ_UNUSED;
        else if (roll < 3 + grow_pct)
            return ($urandom_range(0, 3) == 0) ? REQ_APPEND : REQ_INSERT;
        else
            return REQ_REMOVE;
    endfunction

    initial
    begin
        rst_n               = 1'b0;
        burst_left          = 0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_APPEND;
        req_ch.elem_kind    = '0;
        req_ch.elem_payload = '0;
        req_ch.elem_weight  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(REQ_REMOVE, 1'b0, 9'd0, 32'd0);
        offer_request(REQ_UNUSED, 1'b1, 9'd511, 32'hFFFF_FFFF);
        offer_request(REQ_INSERT, 1'b0, 9'h041, 32'd100);
        offer_request(REQ_INSERT, 1'b1, 9'd511, 32'hFFFF_FFFF);
        offer_request(REQ_INSERT, 1'b0, 9'd2, 32'd1);
        offer_request(REQ_INSERT, 1'b1, 9'd3, 32'd100);
        offer_request(REQ_APPEND, 1'b0, 9'd0, 32'd0);
        offer_request(REQ_APPEND, 1'b1, 9'h1AA, 32'd500);
        offer_request(REQ_INSERT, 1'b0, 9'h155, 32'd200);
        offer_request(REQ_INSERT, 1'b1, 9'd4, 32'd0);
        offer_request(REQ_UNUSED, 1'b0, 9'd7, 32'd9);
        repeat (10) offer_request(REQ_REMOVE, 1'b0, 9'd0, 32'd0);
        offer_request(REQ_APPEND, 1'b1, 9'd511, 32'hFFFF_FFFF);
        offer_request(REQ_REMOVE, 1'b1, 9'd511, 32'hFFFF_FFFF);

        sent        = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_REQUESTS)
        begin
            if (first_phase)
            begin
                phase_len = 320;
                add_pct   = 92;
            end
            else
            begin
                phase_len = $urandom_range(60, 320);
                case ($urandom_range(0, 2))
                    0:       add_pct = 92;
                    1:       add_pct = 8;
                    default: add_pct = 47;
                endcase
            end
            if (phase_len > RANDOM_REQUESTS - sent)
                phase_len = RANDOM_REQUESTS - sent;
            first_phase = 1'b0;
            repeat (phase_len)
            begin
                offer_request(pick_request(add_pct), KIND_W'($urandom_range(0, 1)),
                              PAYLOAD_W'($urandom_range(0, 511)), pick_weight());
                sent++;
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (answers_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
